@@ rtl/gasp_pkg.sv @@
// Shared types, constants and page size selection for the glyph atlas shelf packer.
package gasp_pkg;

    localparam int HGAP_DEF = 2;
    localparam int VGAP_DEF = 2;
    localparam int GRID_N   = 5;
    localparam logic [9:0] SIDE_MIN   = 10'd32;
    localparam logic [9:0] CURSOR_RST = 10'd2;

    typedef struct packed {
        logic        page_open;
        logic [9:0]  cursor_x;
        logic [9:0]  cursor_y;
        logic [7:0]  shelf_height;
        logic [9:0]  page_w;
        logic [9:0]  page_h;
        logic [31:0] area_done;
        logic [7:0]  page_counter;
    } gasp_state_t;

    typedef struct packed {
        logic       placed;
        logic [8:0] pos_x;
        logic [8:0] pos_y;
        logic [7:0] page_index;
        logic [9:0] page_width;
        logic [9:0] page_height;
        logic       prev_page_closed;
        logic       too_large;
    } gasp_result_t;

    // First grid entry (outer index a, inner b) whose area exceeds rem.
    // Sides are powers of two, so each product is a single bit position.
    function automatic logic [19:0] choose_page(input logic [31:0] rem);
        logic        found;
        logic [9:0]  sa;
        logic [9:0]  sb;
        logic [19:0] pick;
        found = 1'b0;
        pick  = {10'd512, 10'd512};
        for (int a = 0; a < GRID_N; a++) begin
            for (int b = 0; b < GRID_N; b++) begin
                sa = SIDE_MIN << a;
                sb = SIDE_MIN << b;
                if (!found && ({1'b0, rem} < (33'd1 << (10 + a + b)))) begin
                    found = 1'b1;
                    pick  = (sa >= sb) ? {sa, sb} : {sb, sa};
                end
            end
        end
        return pick;
    endfunction

endpackage

@@ rtl/glyph_atlas_shelf_packer.sv @@
// Top level of the glyph atlas shelf packer: input register, placement, result register.
//
//  channel | handshake            | word
//  --------+----------------------+--------------------------------------------
//  cfg     | cfg_valid/cfg_ready  | total_area
//  in      | in_valid/in_ready    | glyph_width, glyph_height, first_glyph
//  out     | out_valid/out_ready  | placed, pos_x, pos_y, page_index,
//          |                      | page_width, page_height, prev_page_closed,
//          |                      | too_large
//
// One word per cycle sustained while out_ready stays high. out_valid rises when a word
// reaches the result register from the input register through the placement step (page
// size pick, fit checks, padded area add), which is combinational and updates the page
// state. cfg_ready is always high. Reset clears page state to no open page.
// A stalled output holds its word; the input register then takes one more word and
// holds it until the result register drains.
module glyph_atlas_shelf_packer
    import gasp_pkg::*;
#(
    parameter int HGAP = HGAP_DEF,
    parameter int VGAP = VGAP_DEF
)(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [31:0] total_area,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  glyph_width,
    input  logic [7:0]  glyph_height,
    input  logic        first_glyph,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        placed,
    output logic [8:0]  pos_x,
    output logic [8:0]  pos_y,
    output logic [7:0]  page_index,
    output logic [9:0]  page_width,
    output logic [9:0]  page_height,
    output logic        prev_page_closed,
    output logic        too_large
);

    logic [31:0]  total_area_reg;
    logic         in_valid_reg, in_valid_next;
    logic [7:0]   width_reg, height_reg;
    logic         first_reg;
    logic         out_valid_reg, out_valid_next;
    gasp_result_t res_reg, res_next;
    gasp_state_t  st_reg, st_next;
    logic         advance;

    localparam gasp_state_t ST_RST = '{
        page_open:    1'b0,
        cursor_x:     CURSOR_RST,
        cursor_y:     CURSOR_RST,
        shelf_height: 8'd0,
        page_w:       SIDE_MIN,
        page_h:       SIDE_MIN,
        area_done:    32'd0,
        page_counter: 8'd0
    };

    gasp_place #(
        .HGAP (HGAP),
        .VGAP (VGAP)
    ) u_place (
        .st           (st_reg),
        .total_area   (total_area_reg),
        .glyph_width  (width_reg),
        .glyph_height (height_reg),
        .first_glyph  (first_reg),
        .st_next      (st_next),
        .res          (res_next)
    );

    assign cfg_ready      = 1'b1;
    assign advance        = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready       = !in_valid_reg || advance;
    assign in_valid_next  = (in_valid && in_ready) || (in_valid_reg && !advance);
    assign out_valid_next = advance || (out_valid_reg && !out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_area_reg <= 32'd0;
            in_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            st_reg         <= ST_RST;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                total_area_reg <= total_area;
            end
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (advance)
            begin
                st_reg <= st_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            width_reg  <= glyph_width;
            height_reg <= glyph_height;
            first_reg  <= first_glyph;
        end
        if (advance)
        begin
            res_reg <= res_next;
        end
    end

    assign out_valid        = out_valid_reg;
    assign placed           = res_reg.placed;
    assign pos_x            = res_reg.pos_x;
    assign pos_y            = res_reg.pos_y;
    assign page_index       = res_reg.page_index;
    assign page_width       = res_reg.page_width;
    assign page_height      = res_reg.page_height;
    assign prev_page_closed = res_reg.prev_page_closed;
    assign too_large        = res_reg.too_large;

endmodule

@@ rtl/gasp_place.sv @@
// Placement logic: next packer state and result for one glyph.
module gasp_place
    import gasp_pkg::*;
#(
    parameter int HGAP = HGAP_DEF,
    parameter int VGAP = VGAP_DEF
)(
    input  gasp_state_t  st,
    input  logic [31:0]  total_area,
    input  logic [7:0]   glyph_width,
    input  logic [7:0]   glyph_height,
    input  logic         first_glyph,
    output gasp_state_t  st_next,
    output gasp_result_t res
);

    localparam logic [9:0]  HX  = 10'(HGAP);
    localparam logic [9:0]  VY  = 10'(VGAP);
    localparam logic [11:0] VG12 = 12'(VGAP);

    function automatic logic fits(input logic [9:0] x, input logic [11:0] y,
                                  input logic [7:0] w, input logic [7:0] h,
                                  input logic [9:0] pw, input logic [9:0] ph);
        return (({2'b0, x} + {4'b0, w}) <= ({2'b0, pw} - 12'd1)) &&
               ((y + {4'b0, h}) <= ({2'b0, ph} - 12'd1));
    endfunction

    logic        po;
    logic [31:0] ad;
    logic [7:0]  pc;
    logic [31:0] rem;
    logic [9:0]  nw, nh;
    logic [9:0]  cx, cy, pw, ph;
    logic [7:0]  sh;
    logic [11:0] ny;
    logic        fit1, fit2, fit3;
    logic        skip;
    logic [8:0]  pad_w, pad_h;
    logic [17:0] pad_area;
    logic        place;
    logic [9:0]  px;
    logic [9:0]  py;

    assign po  = first_glyph ? 1'b0  : st.page_open;
    assign ad  = first_glyph ? 32'd0 : st.area_done;
    assign pc  = first_glyph ? 8'd0  : st.page_counter;
    assign rem = total_area - ad;
    assign {nw, nh} = choose_page(rem);

    assign cx = po ? st.cursor_x     : HX;
    assign cy = po ? st.cursor_y     : VY;
    assign sh = po ? st.shelf_height : glyph_height;
    assign pw = po ? st.page_w       : nw;
    assign ph = po ? st.page_h       : nh;
    assign ny = {2'b0, cy} + {4'b0, sh} + VG12;

    assign fit1 = fits(cx, {2'b0, cy}, glyph_width, glyph_height, pw, ph);
    assign fit2 = fits(HX, ny, glyph_width, glyph_height, pw, ph);
    assign fit3 = fits(HX, {2'b0, VY}, glyph_width, glyph_height, nw, nh);

    assign skip     = (glyph_width == 8'd0) || (glyph_height == 8'd0);
    assign pad_w    = {1'b0, glyph_width} + 9'(HGAP);
    assign pad_h    = {1'b0, glyph_height} + 9'(VGAP);
    assign pad_area = pad_w * pad_h;

    always_comb
    begin
        st_next              = st;
        res                  = '0;
        place                = 1'b0;
        px                   = cx;
        py                   = cy;
        st_next.page_open    = po;
        st_next.area_done    = ad;
        st_next.page_counter = pc;
        if (!skip)
        begin
            st_next.page_open    = 1'b1;
            st_next.cursor_x     = cx;
            st_next.cursor_y     = cy;
            st_next.shelf_height = sh;
            st_next.page_w       = pw;
            st_next.page_h       = ph;
            if (fit1)
            begin
                place = 1'b1;
            end
            else if (fit2)
            begin
                st_next.cursor_y     = ny[9:0];
                st_next.shelf_height = glyph_height;
                px                   = HX;
                py                   = ny[9:0];
                place                = 1'b1;
            end
            else if ((cx == HX) && (cy == VY))
            begin
                res.too_large = 1'b1;
            end
            else
            begin
                // close the page and start a fresh one
                res.prev_page_closed = 1'b1;
                if (pc != 8'hFF)
                begin
                    st_next.page_counter = pc + 8'd1;
                end
                st_next.cursor_x     = HX;
                st_next.cursor_y     = VY;
                st_next.shelf_height = glyph_height;
                st_next.page_w       = nw;
                st_next.page_h       = nh;
                px                   = HX;
                py                   = VY;
                if (fit3)
                begin
                    place = 1'b1;
                end
                else
                begin
                    res.too_large = 1'b1;
                end
            end
            if (place)
            begin
                st_next.cursor_x  = px + {2'b0, glyph_width} + HX;
                st_next.area_done = ad + {14'b0, pad_area};
                res.placed        = 1'b1;
                res.pos_x         = px[8:0];
                res.pos_y         = py[8:0];
            end
        end
        res.page_index  = st_next.page_counter;
        res.page_width  = st_next.page_w;
        res.page_height = st_next.page_h;
    end

endmodule

@@ rtl/gasp_checker.sv @@
// Port-level assertions for the glyph atlas shelf packer, bound to the top level.
module gasp_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_ready,
    input logic       placed,
    input logic [8:0] pos_x,
    input logic [8:0] pos_y,
    input logic [7:0] page_index,
    input logic [9:0] page_width,
    input logic [9:0] page_height,
    input logic       prev_page_closed,
    input logic       too_large
);

    a_place_xor_big: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(placed && too_large))
        else $error("word both placed and too large");

    a_unplaced_home: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !placed) |-> ((pos_x == 9'd0) && (pos_y == 9'd0)))
        else $error("unplaced word carries a position");

    a_landscape: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (page_width >= page_height))
        else $error("page taller than wide");

    a_close_counts: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && prev_page_closed) |-> (page_index != 8'd0))
        else $error("page closed but index still zero");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(pos_x) && $stable(pos_y)
                                       && $stable(page_index)))
        else $error("stalled output word changed");

endmodule

bind glyph_atlas_shelf_packer gasp_checker u_gasp_checker (.*);

@@ verif/glyph_atlas_shelf_packer_checker.sv @@
`timescale 1ns / 1ps
// Checker for the glyph atlas shelf packer: predicts each placement and compares results.
module glyph_atlas_shelf_packer_checker
    import gasp_pkg::*;
#(
    parameter int HGAP = HGAP_DEF,
    parameter int VGAP = VGAP_DEF
)(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [31:0] total_area,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic [7:0]  glyph_width,
    input  logic [7:0]  glyph_height,
    input  logic        first_glyph,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic        placed,
    input  logic [8:0]  pos_x,
    input  logic [8:0]  pos_y,
    input  logic [7:0]  page_index,
    input  logic [9:0]  page_width,
    input  logic [9:0]  page_height,
    input  logic        prev_page_closed,
    input  logic        too_large,
    output int          mismatches,
    output int          pending
);

    logic [31:0]  area_budget;
    logic         page_live;
    logic [9:0]   cur_x;
    logic [9:0]   cur_y;
    logic [7:0]   shelf_h;
    logic [9:0]   page_w;
    logic [9:0]   page_h;
    logic [31:0]  area_used;
    logic [7:0]   page_num;
    gasp_result_t placements_due[$];

    function automatic bit fits(input int unsigned x, input int unsigned y,
                                input int unsigned w, input int unsigned h);
        return (x + w <= 32'(page_w) - 1) && (y + h <= 32'(page_h) - 1);
    endfunction

    // Fresh page: cursor home, size is the first grid entry larger than the area left.
    function automatic void open_page(input logic [7:0] h);
        logic [31:0] left;
        bit          done;
        left    = area_budget - area_used;
        done    = 1'b0;
        cur_x   = 10'(HGAP);
        cur_y   = 10'(VGAP);
        shelf_h = h;
        page_w  = 10'd512;
        page_h  = 10'd512;
        for (int a = 0; a < 5; a++)
        begin
            for (int b = 0; b < 5; b++)
            begin
                if (!done && left < (32'd32 << a) * (32'd32 << b))
                begin
                    done   = 1'b1;
                    page_w = 10'(32 << ((a > b) ? a : b));
                    page_h = 10'(32 << ((a > b) ? b : a));
                end
            end
        end
        page_live = 1'b1;
    endfunction

    function automatic gasp_result_t place_glyph(input logic [7:0] w, input logic [7:0] h,
                                                 input logic first);
        gasp_result_t r;
        int unsigned  next_y;
        bit           ok;
        r  = '0;
        ok = 1'b0;
        if (first)
        begin
            page_live = 1'b0;
            area_used = '0;
            page_num  = '0;
        end
        if (w != 0 && h != 0)
        begin
            if (!page_live)
                open_page(h);
            if (fits(32'(cur_x), 32'(cur_y), 32'(w), 32'(h)))
                ok = 1'b1;
            else
            begin
                next_y = 32'(cur_y) + 32'(shelf_h) + VGAP;
                if (fits(HGAP, next_y, 32'(w), 32'(h)))
                begin
                    cur_x   = 10'(HGAP);
                    cur_y   = 10'(next_y);
                    shelf_h = h;
                    ok      = 1'b1;
                end
                else if (cur_x == 10'(HGAP) && cur_y == 10'(VGAP))
                    r.too_large = 1'b1;
                else
                begin
                    r.prev_page_closed = 1'b1;
                    if (page_num != 8'd255)
                        page_num = page_num + 8'd1;
                    open_page(h);
                    if (fits(32'(cur_x), 32'(cur_y), 32'(w), 32'(h)))
                        ok = 1'b1;
                    else
                        r.too_large = 1'b1;
                end
            end
            if (ok)
            begin
                r.placed  = 1'b1;
                r.pos_x   = cur_x[8:0];
                r.pos_y   = cur_y[8:0];
                cur_x     = 10'(32'(cur_x) + 32'(w) + HGAP);
                area_used = area_used + 32'((32'(w) + HGAP) * (32'(h) + VGAP));
            end
        end
        r.page_index  = page_num;
        r.page_width  = page_w;
        r.page_height = page_h;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        gasp_result_t got;
        gasp_result_t want;
        if (!rst_n)
        begin
            area_budget = '0;
            page_live   = 1'b0;
            cur_x       = 10'd2;
            cur_y       = 10'd2;
            shelf_h     = '0;
            page_w      = 10'd32;
            page_h      = 10'd32;
            area_used   = '0;
            page_num    = '0;
            mismatches  = 0;
            placements_due.delete();
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                area_budget = total_area;
            if (out_valid && out_ready)
            begin
                got = '{placed, pos_x, pos_y, page_index, page_width, page_height,
                        prev_page_closed, too_large};
                if (placements_due.size() == 0)
                begin
                    if (mismatches < 10)
                        $display("%0t: result word with nothing pending", $realtime);
                    mismatches++;
                end
                else
                begin
                    want = placements_due.pop_front();
                    if (got !== want)
                    begin
                        if (mismatches < 10)
                        begin
                            $display("%0t: placement mismatch", $realtime);
                            $display(
                                "  exp placed=%0d pos=%0d,%0d page=%0d %0dx%0d closed=%0d big=%0d",
                                want.placed, want.pos_x, want.pos_y, want.page_index,
                                want.page_width, want.page_height,
                                want.prev_page_closed, want.too_large);
                            $display(
                                "  got placed=%0d pos=%0d,%0d page=%0d %0dx%0d closed=%0d big=%0d",
                                got.placed, got.pos_x, got.pos_y, got.page_index,
                                got.page_width, got.page_height,
                                got.prev_page_closed, got.too_large);
                        end
                        mismatches++;
                    end
                end
            end
            if (in_valid && in_ready)
                placements_due.push_back(place_glyph(glyph_width, glyph_height, first_glyph));
        end
        pending = placements_due.size();
    end

endmodule

@@ verif/glyph_atlas_shelf_packer_tb.sv @@
`timescale 1ns / 1ps
// Testbench top for the glyph atlas shelf packer: clock, reset, stimulus, idling and verdict.
module glyph_atlas_shelf_packer_tb;
    import gasp_pkg::*;

    localparam int ITEM_TARGET  = 1050;
    localparam int SAT_RUN      = 262;
    localparam int DRAIN_CYCLES = 4;
    localparam int CYCLE_LIMIT  = 400000;

    logic        clk;
    logic        rst_n;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [31:0] total_area;
    logic        in_valid;
    logic        in_ready;
    logic [7:0]  glyph_width;
    logic [7:0]  glyph_height;
    logic        first_glyph;
    logic        out_valid;
    logic        out_ready;
    logic        placed;
    logic [8:0]  pos_x;
    logic [8:0]  pos_y;
    logic [7:0]  page_index;
    logic [9:0]  page_width;
    logic [9:0]  page_height;
    logic        prev_page_closed;
    logic        too_large;

    int mismatches;
    int pending;
    int glyphs_sent   = 0;
    int cycle_count   = 0;
    int send_idle_pct = 17;
    int recv_idle_pct = 88;
    int stall_req     = 0;

    glyph_atlas_shelf_packer dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .total_area       (total_area),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .glyph_width      (glyph_width),
        .glyph_height     (glyph_height),
        .first_glyph      (first_glyph),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .placed           (placed),
        .pos_x            (pos_x),
        .pos_y            (pos_y),
        .page_index       (page_index),
        .page_width       (page_width),
        .page_height      (page_height),
        .prev_page_closed (prev_page_closed),
        .too_large        (too_large)
    );

    glyph_atlas_shelf_packer_checker placement_check (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .total_area       (total_area),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .glyph_width      (glyph_width),
        .glyph_height     (glyph_height),
        .first_glyph      (first_glyph),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .placed           (placed),
        .pos_x            (pos_x),
        .pos_y            (pos_y),
        .page_index       (page_index),
        .page_width       (page_width),
        .page_height      (page_height),
        .prev_page_closed (prev_page_closed),
        .too_large        (too_large),
        .mismatches       (mismatches),
        .pending          (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    always @(posedge clk)
        cycle_count <= cycle_count + 1;

    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("[glyph_atlas_shelf_packer] ERROR");
        $finish;
    end

    // Result side: random back-pressure, plus long hold-offs on request.
    initial
    begin
        int n;
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (stall_req != 0)
            begin
                n         = stall_req;
                stall_req = 0;
                out_ready <= 1'b0;
                repeat (n) @(negedge clk);
            end
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic write_area(input logic [31:0] value);
        cfg_valid  <= 1'b1;
        total_area <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic send_glyph(input logic [7:0] w, input logic [7:0] h, input logic first);
        if (glyphs_sent < ITEM_TARGET / 3)
        begin
            send_idle_pct = 17;
            recv_idle_pct = 88;
        end
        else if (glyphs_sent < 2 * ITEM_TARGET / 3)
        begin
            send_idle_pct = 88;
            recv_idle_pct = 17;
        end
        else
        begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
        end
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid     <= 1'b1;
        glyph_width  <= w;
        glyph_height <= h;
        first_glyph  <= first;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        glyphs_sent++;
        @(negedge clk);
    endtask

    // Drop valid and wait until every placement word has come back.
    task automatic settle();
        in_valid <= 1'b0;
        wait (pending == 0);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    initial
    begin
        logic [7:0]  font_w [0:39];
        logic [7:0]  font_h [0:39];
        logic [31:0] budget;
        int unsigned sum;
        int          n;
        int          cap;
        int          h;
        int          batch;
        rst_n        = 1'b0;
        cfg_valid    = 1'b0;
        total_area   = '0;
        in_valid     = 1'b0;
        glyph_width  = '0;
        glyph_height = '0;
        first_glyph  = 1'b0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // zero-size skips, shelf fill, new shelf, page full with area overrun
        write_area(32'd0);
        send_glyph(8'd0, 8'd5, 1'b0);
        send_glyph(8'd0, 8'd0, 1'b1);
        send_glyph(8'd255, 8'd0, 1'b0);
        send_glyph(8'd10, 8'd10, 1'b1);
        send_glyph(8'd10, 8'd10, 1'b0);
        send_glyph(8'd10, 8'd8, 1'b0);
        send_glyph(8'd20, 8'd10, 1'b0);
        settle();
        // too large on an empty page, page stays open
        write_area(32'd0);
        send_glyph(8'd40, 8'd5, 1'b1);
        send_glyph(8'd255, 8'd255, 1'b0);
        send_glyph(8'd5, 8'd5, 1'b0);
        settle();
        // page closed, then too large on the fresh one
        write_area(32'd2000);
        send_glyph(8'd5, 8'd5, 1'b1);
        send_glyph(8'd70, 8'd5, 1'b0);
        send_glyph(8'd5, 8'd5, 1'b0);
        settle();
        write_area(32'hFFFF_FFFF);
        send_glyph(8'd255, 8'd255, 1'b1);
        send_glyph(8'd1, 8'd1, 1'b0);
        send_glyph(8'd255, 8'd1, 1'b0);
        send_glyph(8'd1, 8'd255, 1'b0);
        settle();

        batch = 0;
        while (glyphs_sent < ITEM_TARGET - SAT_RUN)
        begin
            if (batch % 6 == 4)
                stall_req = $urandom_range(30, 90);
            if ($urandom_range(3) != 0)
            begin
                // font run: heights descending, budget from the padded sum
                n = $urandom_range(4, 40);
                case ($urandom_range(9))
                    0, 1, 2, 3: cap = 8;
                    4, 5, 6:    cap = 24;
                    7:          cap = 64;
                    8:          cap = 128;
                    default:    cap = 255;
                endcase
                h   = $urandom_range(1, cap);
                sum = 0;
                for (int i = 0; i < n; i++)
                begin
                    font_h[i] = 8'(h);
                    font_w[i] = 8'($urandom_range(1, cap));
                    if ($urandom_range(24) == 0)
                        font_w[i] = 8'd0;
                    sum = sum + (32'(font_w[i]) + 2) * (32'(font_h[i]) + 2);
                    h   = h - $urandom_range(0, (h - 1) / 3);
                end
                case ($urandom_range(7))
                    0:       budget = sum / 2;
                    1:       budget = sum * 3;
                    default: budget = sum;
                endcase
                write_area(budget);
                for (int i = 0; i < n; i++)
                    send_glyph(font_w[i], font_h[i], i == 0);
            end
            else
            begin
                case ($urandom_range(4))
                    0:       budget = 32'd0;
                    1:       budget = 32'hFFFF_FFFF;
                    2:       budget = $urandom_range(500, 20000);
                    default: budget = $urandom();
                endcase
                write_area(budget);
                n = $urandom_range(5, 30);
                for (int i = 0; i < n; i++)
                    send_glyph(($urandom_range(7) == 0) ? 8'd0 : 8'($urandom_range(255)),
                               ($urandom_range(7) == 0) ? 8'd0 : 8'($urandom_range(255)),
                               (i == 0) || ($urandom_range(9) == 0));
            end
            settle();
            batch++;
        end

        // one glyph per page on full-size pages until the page index saturates
        stall_req = 100;
        write_area(32'hFFFF_FFFF);
        for (int i = 0; i < SAT_RUN; i++)
            send_glyph(8'($urandom_range(254, 255)), 8'($urandom_range(254, 255)), i == 0);
        settle();

        if (mismatches == 0 && pending == 0)
        begin
            $display("[glyph_atlas_shelf_packer] OK");
        end
        else
        begin
            $display("[glyph_atlas_shelf_packer] ERROR");
        end
        $finish;
    end

endmodule

@@ sim.f @@
rtl/gasp_pkg.sv
rtl/gasp_place.sv
rtl/glyph_atlas_shelf_packer.sv
rtl/gasp_checker.sv
verif/glyph_atlas_shelf_packer_checker.sv
verif/glyph_atlas_shelf_packer_tb.sv
